// ===== rtl/core/esap_pkg.sv =====
// ----------------------------------------------------------------------------
// esap_pkg
// Shared widths, character codes and phase encodings for the escape sequence
// argument parser.
// ----------------------------------------------------------------------------
package esap_pkg;

	// default sizing of the argument store and of one argument's text
	localparam int MAX_ARGS_DEF  = 16;
	localparam int ARG_CHARS_DEF = 16;

	// fixed field widths
	localparam int BYTE_W  = 8;
	localparam int VALUE_W = 32;
	localparam int INDEX_W = 4;
	localparam int COUNT_W = 5;
	localparam int KIND_W  = 3;

	// character codes
	localparam logic [BYTE_W-1:0] CH_ESC   = 8'h1B;
	localparam logic [BYTE_W-1:0] CH_LBR   = 8'h5B; // '['
	localparam logic [BYTE_W-1:0] CH_QUEST = 8'h3F; // '?'
	localparam logic [BYTE_W-1:0] CH_RBR   = 8'h5D; // ']'
	localparam logic [BYTE_W-1:0] CH_M     = 8'h6D; // 'm'
	localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B; // ';'
	localparam logic [BYTE_W-1:0] CH_L     = 8'h6C; // 'l'
	localparam logic [BYTE_W-1:0] CH_H     = 8'h68; // 'h'
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

	// sequence kinds reported at the end of a sequence
	localparam logic [KIND_W-1:0] END_SGR     = 3'd0;
	localparam logic [KIND_W-1:0] END_PRIVATE = 3'd1;
	localparam logic [KIND_W-1:0] END_OSC     = 3'd2;
	localparam logic [KIND_W-1:0] END_FULL    = 3'd3;
	localparam logic [KIND_W-1:0] END_BUFFER  = 3'd4;

	// parse phase codes
	localparam logic [2:0] PH_IDLE      = 3'd0;
	localparam logic [2:0] PH_START     = 3'd1;
	localparam logic [2:0] PH_AFTER_ESC = 3'd2;
	localparam logic [2:0] PH_AFTER_BR  = 3'd3;
	localparam logic [2:0] PH_PRIVATE   = 3'd4;
	localparam logic [2:0] PH_ARGS      = 3'd5;

	// number conversion phase codes
	localparam logic [1:0] CV_SPACE  = 2'd0;
	localparam logic [1:0] CV_SIGN   = 2'd1;
	localparam logic [1:0] CV_DIGITS = 2'd2;
	localparam logic [1:0] CV_DONE   = 2'd3;

	// magnitude saturation point
	localparam logic [VALUE_W-1:0] MAG_CAP = 32'h8000_0000;
	localparam logic [VALUE_W-1:0] POS_MAX = 32'h7FFF_FFFF;

	typedef logic [BYTE_W-1:0]  byte_t;
	typedef logic [VALUE_W-1:0] mag_t;

endpackage

// ===== rtl/core/esap_byte_if.sv =====
// ----------------------------------------------------------------------------
// esap_byte_if
// Request channel carrying one terminal byte with its start and end flags.
// ----------------------------------------------------------------------------
interface esap_byte_if;
	import esap_pkg::*;

	logic  valid;
	logic  ready;
	byte_t byte_value;
	logic  first_byte;
	logic  last_byte;

	modport source (output valid, output byte_value, output first_byte, output last_byte,
		input ready);
	modport sink (input valid, input byte_value, input first_byte, input last_byte,
		output ready);

endinterface

// ===== rtl/core/esap_arg_if.sv =====
// ----------------------------------------------------------------------------
// esap_arg_if
// Request channel carrying one parsed argument and sequence end status.
// ----------------------------------------------------------------------------
interface esap_arg_if;
	import esap_pkg::*;

	logic                      valid;
	logic                      ready;
	logic                      arg_valid;
	logic signed [VALUE_W-1:0] arg_value;
	logic [INDEX_W-1:0]        arg_index;
	logic                      seq_end;
	logic [KIND_W-1:0]         end_kind;
	logic                      terminator_consumed;
	logic [COUNT_W-1:0]        arg_count;

	modport source (output valid, output arg_valid, output arg_value, output arg_index,
		output seq_end, output end_kind, output terminator_consumed, output arg_count,
		input ready);
	modport sink (input valid, input arg_valid, input arg_value, input arg_index,
		input seq_end, input end_kind, input terminator_consumed, input arg_count,
		output ready);

endinterface

// ===== rtl/core/escape_sequence_arg_parser.sv =====
// ----------------------------------------------------------------------------
// escape_sequence_arg_parser
// Parses ANSI CSI / SGR parameter bytes into saturated 32-bit arguments.
// ----------------------------------------------------------------------------
// Takes one terminal byte per cycle and gives one request on the args channel
// for each byte that completes an argument or ends a sequence; other bytes
// give nothing. A byte goes into an input register, is parsed by a single
// pass through the phase logic and the times-ten accumulator, and lands in
// the result register; the sustained rate is one byte per cycle while
// args.ready is high. A result waiting in the result register stalls the
// parse pass; the input register then holds its byte and the byte channel
// stalls until the result is taken.
module escape_sequence_arg_parser #(
	parameter int MAX_ARGS  = esap_pkg::MAX_ARGS_DEF,
	parameter int ARG_CHARS = esap_pkg::ARG_CHARS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	esap_byte_if.sink  term,
	esap_arg_if.source args
);
	import esap_pkg::*;

	localparam int CNT_W  = $clog2(MAX_ARGS + 1);
	localparam int PEND_W = $clog2(ARG_CHARS + 1);

	// input register
	logic         vld_s1;
	byte_t        byte_s1;
	logic         first_s1;
	logic         last_s1;

	// parser state
	logic [2:0]        phase_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [PEND_W-1:0] pend_q;
	logic [1:0]        cv_q;
	logic              neg_q;
	mag_t              mag_q;

	// result register
	logic                      ovld_q;
	logic                      arg_valid_q;
	logic signed [VALUE_W-1:0] arg_value_q;
	logic [INDEX_W-1:0]        arg_index_q;
	logic                      seq_end_q;
	logic [KIND_W-1:0]         end_kind_q;
	logic                      cons_q;
	logic [COUNT_W-1:0]        arg_count_q;

	// next-state and result of the parse pass
	logic [2:0]        ph_n;
	logic [CNT_W-1:0]  cnt_n;
	logic [PEND_W-1:0] pend_n;
	logic [1:0]        cv_n;
	logic              neg_n;
	mag_t              mag_n;
	logic              res_vld;
	logic              r_valid;
	mag_t              r_value;
	logic [CNT_W-1:0]  r_idx;
	logic              r_end;
	logic [KIND_W-1:0] r_kind;
	logic              r_cons;

	logic advance;

	// zero-extended copies for the narrow output fields
	logic [CNT_W+COUNT_W-1:0] cnt_ext;
	logic [CNT_W+INDEX_W-1:0] idx_ext;

	assign advance    = vld_s1 && (!ovld_q || args.ready);
	assign term.ready = !vld_s1 || advance;

	// one parse pass over the registered byte
	always_comb begin
		logic               taken;
		logic               digit;
		logic               space;
		logic               feed_dig;
		logic [VALUE_W+3:0] prod;
		mag_t               conv;

		ph_n     = phase_q;
		cnt_n    = cnt_q;
		pend_n   = pend_q;
		cv_n     = cv_q;
		neg_n    = neg_q;
		mag_n    = mag_q;
		r_valid  = 1'b0;
		r_value  = '0;
		r_idx    = '0;
		r_end    = 1'b0;
		r_kind   = END_SGR;
		r_cons   = 1'b0;
		taken    = 1'b0;
		feed_dig = 1'b0;
		prod     = '0;

		digit = (byte_s1 >= CH_ZERO) && (byte_s1 <= CH_NINE);
		space = (byte_s1 == CH_SPACE) || ((byte_s1 >= CH_TAB) && (byte_s1 <= CH_CR));

		// restart on the first byte of a buffer
		if (first_s1) begin
			ph_n   = PH_START;
			cnt_n  = '0;
			pend_n = '0;
			cv_n   = CV_SPACE;
			neg_n  = 1'b0;
			mag_n  = '0;
		end

		// value of the argument held so far
		if (neg_n) begin
			conv = '0 - mag_n;
		end else if (mag_n >= MAG_CAP) begin
			conv = POS_MAX;
		end else begin
			conv = mag_n;
		end

		if (ph_n != PH_IDLE) begin
			// optional ESC, then optional '['
			if (ph_n == PH_START) begin
				taken = (byte_s1 == CH_ESC);
				ph_n  = PH_AFTER_ESC;
			end
			if (!taken && ph_n == PH_AFTER_ESC) begin
				taken = (byte_s1 == CH_LBR);
				ph_n  = PH_AFTER_BR;
			end
			// private mode, OSC or plain arguments
			if (!taken && ph_n == PH_AFTER_BR) begin
				if (byte_s1 == CH_QUEST) begin
					taken = 1'b1;
					ph_n  = PH_PRIVATE;
				end else if (byte_s1 == CH_RBR) begin
					taken  = 1'b1;
					cnt_n  = CNT_W'(1);
					r_end  = 1'b1;
					r_kind = END_OSC;
					r_cons = 1'b1;
				end else begin
					ph_n = PH_ARGS;
				end
			end
			// skip private mode through 'l' or 'h'
			if (!taken && ph_n == PH_PRIVATE) begin
				taken = 1'b1;
				if (byte_s1 == CH_L || byte_s1 == CH_H) begin
					r_end  = 1'b1;
					r_kind = END_PRIVATE;
					r_cons = 1'b1;
				end
			end
			// argument collection
			if (!taken && ph_n == PH_ARGS) begin
				if (byte_s1 == CH_M) begin
					if (pend_n != '0 && cnt_n >= CNT_W'(MAX_ARGS)) begin
						r_end  = 1'b1;
						r_kind = END_FULL;
					end else begin
						if (pend_n != '0) begin
							r_valid = 1'b1;
							r_value = conv;
							r_idx   = cnt_n;
							cnt_n   = cnt_n + CNT_W'(1);
						end
						r_end  = 1'b1;
						r_kind = END_SGR;
						r_cons = 1'b1;
					end
				end else if (byte_s1 == CH_SEMI) begin
					if (cnt_n >= CNT_W'(MAX_ARGS)) begin
						r_end  = 1'b1;
						r_kind = END_FULL;
					end else begin
						r_valid = 1'b1;
						r_value = conv;
						r_idx   = cnt_n;
						cnt_n   = cnt_n + CNT_W'(1);
						pend_n  = '0;
						cv_n    = CV_SPACE;
						neg_n   = 1'b0;
						mag_n   = '0;
					end
				end else begin
					// drop held text once the character budget is used up
					if (pend_n >= PEND_W'(ARG_CHARS)) begin
						pend_n = '0;
						cv_n   = CV_SPACE;
						neg_n  = 1'b0;
						mag_n  = '0;
					end
					pend_n = pend_n + PEND_W'(1);
					unique case (cv_n)
						CV_SPACE: begin
							if (!space) begin
								if (byte_s1 == CH_PLUS || byte_s1 == CH_MINUS) begin
									neg_n = (byte_s1 == CH_MINUS);
									cv_n  = CV_SIGN;
								end else begin
									cv_n     = digit ? CV_DIGITS : CV_DONE;
									feed_dig = digit;
								end
							end
						end
						CV_SIGN: begin
							cv_n     = digit ? CV_DIGITS : CV_DONE;
							feed_dig = digit;
						end
						CV_DIGITS: begin
							if (digit) begin
								feed_dig = 1'b1;
							end else begin
								cv_n = CV_DONE;
							end
						end
						default: begin
						end
					endcase
					// magnitude times ten plus digit, saturated
					if (feed_dig) begin
						prod = ({4'b0, mag_n} << 3) + ({4'b0, mag_n} << 1)
							+ (VALUE_W+4)'(byte_s1 - CH_ZERO);
						mag_n = (prod > {4'b0, MAG_CAP}) ? MAG_CAP : prod[VALUE_W-1:0];
					end
				end
			end
			// buffer exhausted
			if (!r_end && last_s1) begin
				r_end  = 1'b1;
				r_kind = END_BUFFER;
				r_cons = 1'b1;
			end
			if (r_end) begin
				ph_n = PH_IDLE;
			end
		end
	end

	assign res_vld = r_valid || r_end;
	assign cnt_ext = {{COUNT_W{1'b0}}, cnt_n};
	assign idx_ext = {{INDEX_W{1'b0}}, r_idx};

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (term.ready) begin
			vld_s1 <= term.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (term.valid && term.ready) begin
			byte_s1  <= term.byte_value;
			first_s1 <= term.first_byte;
			last_s1  <= term.last_byte;
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
			pend_q  <= '0;
			cv_q    <= CV_SPACE;
			neg_q   <= 1'b0;
			mag_q   <= '0;
		end else if (advance) begin
			phase_q <= ph_n;
			cnt_q   <= cnt_n;
			pend_q  <= pend_n;
			cv_q    <= cv_n;
			neg_q   <= neg_n;
			mag_q   <= mag_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
		end else if (advance && res_vld) begin
			ovld_q <= 1'b1;
		end else if (args.ready) begin
			ovld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_vld) begin
			arg_valid_q <= r_valid;
			arg_value_q <= r_value;
			arg_index_q <= idx_ext[INDEX_W-1:0];
			seq_end_q   <= r_end;
			end_kind_q  <= r_kind;
			cons_q      <= r_cons;
			arg_count_q <= cnt_ext[COUNT_W-1:0];
		end
	end

	assign args.valid               = ovld_q;
	assign args.arg_valid           = arg_valid_q;
	assign args.arg_value           = arg_value_q;
	assign args.arg_index           = arg_index_q;
	assign args.seq_end             = seq_end_q;
	assign args.end_kind            = end_kind_q;
	assign args.terminator_consumed = cons_q;
	assign args.arg_count           = arg_count_q;

endmodule

// ===== rtl/core/esap_checker.sv =====
// ----------------------------------------------------------------------------
// esap_checker
// Port-level checks on the result channel of the argument parser.
// ----------------------------------------------------------------------------
module esap_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic                               arg_valid,
	input logic signed [esap_pkg::VALUE_W-1:0] arg_value,
	input logic [esap_pkg::INDEX_W-1:0]       arg_index,
	input logic                               seq_end,
	input logic [esap_pkg::KIND_W-1:0]        end_kind,
	input logic                               terminator_consumed,
	input logic [esap_pkg::COUNT_W-1:0]       arg_count
);
	import esap_pkg::*;

	// a stalled result holds its contents
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(arg_valid) && $stable(arg_value)
			&& $stable(seq_end) && $stable(end_kind) && $stable(arg_count))
		else $error("stalled result changed");

	// every result carries an argument or an end
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> arg_valid || seq_end)
		else $error("empty result");

	// no argument means value and index read zero
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !arg_valid |-> arg_value == '0 && arg_index == '0)
		else $error("argument fields set without argument");

	// end fields only mean something at the end of a sequence
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !seq_end |-> end_kind == END_SGR && !terminator_consumed)
		else $error("end fields set without end");

	// a store-full end leaves its byte unconsumed, every other end takes it
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && seq_end |-> (end_kind == END_FULL) == !terminator_consumed)
		else $error("terminator flag disagrees with end kind");

endmodule

bind escape_sequence_arg_parser esap_checker u_esap_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.out_valid           (args.valid),
	.out_ready           (args.ready),
	.arg_valid           (args.arg_valid),
	.arg_value           (args.arg_value),
	.arg_index           (args.arg_index),
	.seq_end             (args.seq_end),
	.end_kind            (args.end_kind),
	.terminator_consumed (args.terminator_consumed),
	.arg_count           (args.arg_count)
);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the escape sequence argument parser. Terminal bytes
// go in on the byte channel and every result on the args channel is checked
// field by field against an in-bench model or a given result. A short directed
// list goes first, then random sequences, mostly well formed, some noise.
// ----------------------------------------------------------------------------
module tb;
	import esap_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int BYTE_TARGET = 1550;
	localparam int DRAIN_CYCLES = 8;
	localparam logic [KIND_W-1:0] NO_END = '0;

	typedef struct packed {
		logic                      arg_valid;
		logic signed [VALUE_W-1:0] arg_value;
		logic [INDEX_W-1:0]        arg_index;
		logic                      seq_end;
		logic [KIND_W-1:0]         end_kind;
		logic                      term_used;
		logic [COUNT_W-1:0]        arg_count;
	} arg_rec_t;

	typedef enum logic [1:0] {EXP_PREDICT, EXP_NONE, EXP_GIVEN} exp_mode_t;

	typedef struct {
		byte_t     b;
		bit        first;
		bit        last;
		exp_mode_t mode;
		arg_rec_t  given;
	} stim_row_t;

	logic clk;
	logic arst_n;

	esap_byte_if term_ch();
	esap_arg_if  args_ch();

	escape_sequence_arg_parser i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.term   (term_ch),
		.args   (args_ch)
	);

	// bench state
	arg_rec_t  expected_args[$];
	stim_row_t directed_rows[$];
	int        n_errors;
	int        n_cycles = 0;
	int        n_items;
	int        n_checked;
	int        kind_seen[5];
	bit        steady_stretch;

	// parser model state
	logic [2:0]         pr_phase;
	int                 pr_stored;
	int                 pr_pending;
	logic [1:0]         pr_conv;
	logic               pr_negative;
	logic [VALUE_W-1:0] pr_magnitude;

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		n_cycles <= n_cycles + 1;
		if (n_cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", n_cycles);
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		n_errors++;
		if (n_errors <= 50)
			$display("ERROR cycle %0d: %s", n_cycles, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	function automatic arg_rec_t mk_result(input logic v, input logic [31:0] val,
		input logic [3:0] idx, input logic e, input logic [2:0] k, input logic u,
		input logic [4:0] cnt);
		arg_rec_t r;
		r.arg_valid = v;
		r.arg_value = val;
		r.arg_index = idx;
		r.seq_end   = e;
		r.end_kind  = k;
		r.term_used = u;
		r.arg_count = cnt;
		return r;
	endfunction

	// atoi style conversion, restarted per argument
	function automatic void clear_number();
		pr_conv      = CV_SPACE;
		pr_negative  = 1'b0;
		pr_magnitude = '0;
	endfunction

	function automatic void feed_number(input byte_t c);
		logic       dig;
		logic [63:0] grown;
		dig = (c >= CH_ZERO) && (c <= CH_NINE);
		if (pr_conv == CV_SPACE) begin
			if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
				return;
			if (c == CH_PLUS || c == CH_MINUS) begin
				pr_negative = (c == CH_MINUS);
				pr_conv = CV_SIGN;
				return;
			end
			pr_conv = dig ? CV_DIGITS : CV_DONE;
		end else if (pr_conv == CV_SIGN) begin
			pr_conv = dig ? CV_DIGITS : CV_DONE;
		end else if (pr_conv == CV_DIGITS && !dig) begin
			pr_conv = CV_DONE;
		end
		if (pr_conv == CV_DIGITS) begin
			grown = 64'(pr_magnitude) * 64'd10 + 64'(c - CH_ZERO);
			pr_magnitude = (grown > 64'(MAG_CAP)) ? MAG_CAP : grown[31:0];
		end
	endfunction

	function automatic logic [VALUE_W-1:0] number_value();
		if (pr_negative)
			return '0 - pr_magnitude;
		return (pr_magnitude >= MAG_CAP) ? POS_MAX : pr_magnitude;
	endfunction

	// one byte through the parser model; returns 1 when a result is due
	function automatic bit predict_args(input byte_t b, input bit first, input bit last,
		output arg_rec_t r);
		bit taken;
		bit fin;
		r = '0;
		taken = 1'b0;
		fin = 1'b0;
		if (first) begin
			pr_stored = 0;
			pr_pending = 0;
			clear_number();
			pr_phase = PH_START;
		end
		if (pr_phase == PH_IDLE)
			return 1'b0;
		// optional prefix bytes
		if (pr_phase == PH_START) begin
			if (b == CH_ESC)
				taken = 1'b1;
			pr_phase = PH_AFTER_ESC;
		end
		if (!taken && pr_phase == PH_AFTER_ESC) begin
			if (b == CH_LBR)
				taken = 1'b1;
			pr_phase = PH_AFTER_BR;
		end
		if (!taken && pr_phase == PH_AFTER_BR) begin
			if (b == CH_QUEST) begin
				taken = 1'b1;
				pr_phase = PH_PRIVATE;
			end else if (b == CH_RBR) begin
				taken = 1'b1;
				pr_stored = 1;
				fin = 1'b1;
				r.end_kind = END_OSC;
				r.term_used = 1'b1;
			end else begin
				pr_phase = PH_ARGS;
			end
		end
		// private mode skipped up to its terminator
		if (!taken && pr_phase == PH_PRIVATE) begin
			taken = 1'b1;
			if (b == CH_L || b == CH_H) begin
				fin = 1'b1;
				r.end_kind = END_PRIVATE;
				r.term_used = 1'b1;
			end
		end
		// argument collection
		if (!taken && pr_phase == PH_ARGS) begin
			if (b == CH_M) begin
				fin = 1'b1;
				if (pr_pending > 0 && pr_stored >= MAX_ARGS_DEF) begin
					r.end_kind = END_FULL;
				end else begin
					if (pr_pending > 0) begin
						r.arg_valid = 1'b1;
						r.arg_value = number_value();
						r.arg_index = pr_stored[3:0];
						pr_stored++;
					end
					r.end_kind = END_SGR;
					r.term_used = 1'b1;
				end
			end else if (b == CH_SEMI) begin
				if (pr_stored >= MAX_ARGS_DEF) begin
					fin = 1'b1;
					r.end_kind = END_FULL;
				end else begin
					r.arg_valid = 1'b1;
					r.arg_value = number_value();
					r.arg_index = pr_stored[3:0];
					pr_stored++;
					pr_pending = 0;
					clear_number();
				end
			end else begin
				if (pr_pending >= ARG_CHARS_DEF) begin
					pr_pending = 0;
					clear_number();
				end
				pr_pending++;
				feed_number(b);
			end
		end
		// buffer exhausted
		if (!fin && last) begin
			fin = 1'b1;
			r.end_kind = END_BUFFER;
			r.term_used = 1'b1;
		end
		if (fin)
			pr_phase = PH_IDLE;
		r.seq_end = fin;
		r.arg_count = pr_stored[4:0];
		return fin || r.arg_valid;
	endfunction

	// drive one byte request and wait for it to be taken
	task automatic send_byte(input byte_t b, input bit first, input bit last,
		input exp_mode_t mode, input arg_rec_t given);
		arg_rec_t r;
		bit       due;
		while (!steady_stretch && $urandom_range(99) < 33) begin
			term_ch.valid <= 1'b0;
			@(posedge clk);
		end
		term_ch.valid      <= 1'b1;
		term_ch.byte_value <= b;
		term_ch.first_byte <= first;
		term_ch.last_byte  <= last;
		@(posedge clk);
		while (!term_ch.ready)
			@(posedge clk);
		n_items++;
		due = predict_args(b, first, last, r);
		if (mode == EXP_GIVEN)
			expected_args.push_back(given);
		else if (mode == EXP_PREDICT && due)
			expected_args.push_back(r);
	endtask

	task automatic add_row(input byte_t b, input bit first, input bit last,
		input exp_mode_t mode, input arg_rec_t given);
		stim_row_t row;
		row.b = b;
		row.first = first;
		row.last = last;
		row.mode = mode;
		row.given = given;
		directed_rows.push_back(row);
	endtask

	// text of one argument: boundary numbers, garbage or whitespace/sign/digits
	function automatic void add_arg_text(ref byte_t seq[$]);
		int    style;
		int    n;
		string lit;
		style = $urandom_range(9);
		if (style == 0) begin
			case ($urandom_range(5))
				0: lit = "2147483647";
				1: lit = "2147483648";
				2: lit = "-2147483648";
				3: lit = "-2147483649";
				4: lit = "99999999999999";
				default: lit = "-0";
			endcase
			foreach (lit[i])
				seq.push_back(lit[i]);
		end else if (style == 1) begin
			n = $urandom_range(1, 6);
			repeat (n)
				seq.push_back(byte_t'($urandom_range(255)));
		end else begin
			if ($urandom_range(3) == 0)
				repeat ($urandom_range(1, 3))
					seq.push_back(byte_t'($urandom_range(1) ? CH_SPACE :
						$urandom_range(CH_TAB, CH_CR)));
			if ($urandom_range(2) == 0)
				seq.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
			n = ($urandom_range(4) == 0) ? $urandom_range(9, 20) : $urandom_range(0, 4);
			repeat (n)
				seq.push_back(byte_t'($urandom_range(CH_ZERO, CH_NINE)));
			if ($urandom_range(7) == 0)
				seq.push_back(byte_t'($urandom_range(255)));
		end
	endfunction

	// one random sequence, then its bytes with start and end flags
	task automatic send_random_sequence();
		byte_t seq[$];
		int    pick;
		int    nargs;
		bit    noise;
		bit    end_flag;
		bit    first;
		bit    last;
		pick = $urandom_range(99);
		noise = (pick >= 85);
		if (!noise && $urandom_range(3) != 0)
			seq.push_back(CH_ESC);
		if (!noise && $urandom_range(3) != 0)
			seq.push_back(CH_LBR);
		if (pick < 65) begin
			nargs = ($urandom_range(7) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 5);
			for (int a = 0; a < nargs; a++) begin
				if (a != 0)
					seq.push_back(CH_SEMI);
				add_arg_text(seq);
			end
			if ($urandom_range(9) != 0)
				seq.push_back(CH_M);
		end else if (pick < 78) begin
			seq.push_back(CH_QUEST);
			repeat ($urandom_range(0, 4))
				seq.push_back(byte_t'($urandom_range(1) ? $urandom_range(CH_ZERO, CH_NINE) :
					$urandom_range(255)));
			if ($urandom_range(7) != 0)
				seq.push_back($urandom_range(1) ? CH_L : CH_H);
		end else if (pick < 85) begin
			seq.push_back(CH_RBR);
		end else begin
			repeat ($urandom_range(1, 12))
				seq.push_back(byte_t'($urandom_range(255)));
		end
		// stray bytes behind the sequence
		if ($urandom_range(4) == 0)
			repeat ($urandom_range(1, 2))
				seq.push_back(byte_t'($urandom_range(255)));
		if (seq.size() == 0)
			seq.push_back(CH_M);
		end_flag = ($urandom_range(2) == 0);
		foreach (seq[i]) begin
			first = (i == 0) && !(noise && $urandom_range(3) == 0);
			last = (i == seq.size() - 1) ? end_flag : (noise && $urandom_range(9) == 0);
			send_byte(seq[i], first, last, EXP_PREDICT, '0);
		end
	endtask

	// result side: random stalls and checking
	always @(posedge clk) begin
		if (arst_n) begin
			if (args_ch.valid && args_ch.ready) begin
				if (expected_args.size() == 0) begin
					report_mismatch("result with nothing expected");
				end else begin
					arg_rec_t want;
					want = expected_args.pop_front();
					n_checked++;
					if (want.seq_end)
						kind_seen[want.end_kind]++;
					check_field("arg_valid", 32'(args_ch.arg_valid), 32'(want.arg_valid));
					check_field("arg_value", args_ch.arg_value, want.arg_value);
					check_field("arg_index", 32'(args_ch.arg_index), 32'(want.arg_index));
					check_field("seq_end", 32'(args_ch.seq_end), 32'(want.seq_end));
					check_field("end_kind", 32'(args_ch.end_kind), 32'(want.end_kind));
					check_field("terminator_consumed", 32'(args_ch.terminator_consumed),
						32'(want.term_used));
					check_field("arg_count", 32'(args_ch.arg_count), 32'(want.arg_count));
				end
			end
			args_ch.ready <= steady_stretch || ($urandom_range(99) >= 33);
		end else begin
			args_ch.ready <= 1'b0;
		end
	end

	// stimulus
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		term_ch.valid = 1'b0;
		term_ch.byte_value = '0;
		term_ch.first_byte = 1'b0;
		term_ch.last_byte = 1'b0;
		n_errors = 0;
		n_items = 0;
		n_checked = 0;
		steady_stretch = 1'b0;
		pr_phase = PH_IDLE;
		pr_stored = 0;
		pr_pending = 0;
		clear_number();

		// directed list
		// byte while idle is ignored
		add_row("x", 1'b0, 1'b0, EXP_NONE, '0);
		// empty argument on ';'
		add_row(CH_ESC, 1'b1, 1'b0, EXP_PREDICT, '0);
		add_row(CH_LBR, 1'b0, 1'b0, EXP_PREDICT, '0);
		add_row(CH_SEMI, 1'b0, 1'b0, EXP_GIVEN,
			mk_result(1'b1, 32'd0, 4'd0, 1'b0, NO_END, 1'b0, 5'd1));
		// whitespace, sign, then a NUL that stops the number
		add_row(CH_SPACE, 1'b0, 1'b0, EXP_PREDICT, '0);
		add_row(CH_PLUS, 1'b0, 1'b0, EXP_PREDICT, '0);
		add_row("5", 1'b0, 1'b0, EXP_PREDICT, '0);
		add_row(8'h00, 1'b0, 1'b0, EXP_PREDICT, '0);
		add_row("3", 1'b0, 1'b0, EXP_PREDICT, '0);
		add_row(CH_M, 1'b0, 1'b0, EXP_PREDICT, '0);
		// osc start
		add_row(CH_RBR, 1'b1, 1'b0, EXP_GIVEN,
			mk_result(1'b0, 32'd0, 4'd0, 1'b1, END_OSC, 1'b1, 5'd1));
		// private mode
		add_row(CH_QUEST, 1'b1, 1'b0, EXP_PREDICT, '0);
		add_row("2", 1'b0, 1'b0, EXP_PREDICT, '0);
		add_row(CH_H, 1'b0, 1'b0, EXP_GIVEN,
			mk_result(1'b0, 32'd0, 4'd0, 1'b1, END_PRIVATE, 1'b1, 5'd0));
		// single byte buffer, top byte value
		add_row(8'hFF, 1'b1, 1'b1, EXP_GIVEN,
			mk_result(1'b0, 32'd0, 4'd0, 1'b1, END_BUFFER, 1'b1, 5'd0));
		// empty argument on 'm'
		add_row(CH_ESC, 1'b1, 1'b0, EXP_PREDICT, '0);
		add_row(CH_M, 1'b0, 1'b0, EXP_GIVEN,
			mk_result(1'b0, 32'd0, 4'd0, 1'b1, END_SGR, 1'b1, 5'd0));
		// buffer holding only a prefix
		add_row(CH_ESC, 1'b1, 1'b1, EXP_GIVEN,
			mk_result(1'b0, 32'd0, 4'd0, 1'b1, END_BUFFER, 1'b1, 5'd0));
		// private mode cut off by buffer end
		add_row(CH_LBR, 1'b1, 1'b0, EXP_PREDICT, '0);
		add_row(CH_QUEST, 1'b0, 1'b0, EXP_PREDICT, '0);
		add_row("x", 1'b0, 1'b1, EXP_GIVEN,
			mk_result(1'b0, 32'd0, 4'd0, 1'b1, END_BUFFER, 1'b1, 5'd0));
		// ';' as last byte reports argument and buffer end together
		add_row(CH_LBR, 1'b1, 1'b0, EXP_PREDICT, '0);
		add_row(CH_SEMI, 1'b0, 1'b1, EXP_GIVEN,
			mk_result(1'b1, 32'd0, 4'd0, 1'b1, END_BUFFER, 1'b1, 5'd1));
		// byte after the end is ignored
		add_row("7", 1'b0, 1'b0, EXP_NONE, '0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_byte(directed_rows[i].b, directed_rows[i].first, directed_rows[i].last,
				directed_rows[i].mode, directed_rows[i].given);

		// random sequences, with one stretch of full throughput
		while (n_items < BYTE_TARGET) begin
			steady_stretch <= (n_items >= 700 && n_items < 1000);
			send_random_sequence();
		end
		term_ch.valid <= 1'b0;
		steady_stretch <= 1'b0;

		while (expected_args.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("parsed %0d bytes in %0d cycles, checked %0d results", n_items, n_cycles,
			n_checked);
		$display("sequence ends: m %0d, private %0d, osc %0d, store full %0d, buffer %0d",
			kind_seen[END_SGR], kind_seen[END_PRIVATE], kind_seen[END_OSC],
			kind_seen[END_FULL], kind_seen[END_BUFFER]);
		if (n_errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/esap_pkg.sv
rtl/core/esap_byte_if.sv
rtl/core/esap_arg_if.sv
rtl/core/escape_sequence_arg_parser.sv
rtl/core/esap_checker.sv
tb/tb.sv
